// ===== hdl/mcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mcbp_pkg: shared definitions for the multi-channel byte pipe
// Sizes, pipe table entry layout, operation and status codes, and
// the controller state type.
// ----------------------------------------------------------------------------
package mcbp_pkg;

    localparam int NUM_PIPES   = 8;
    localparam int PIPE_DEPTH  = 256;
    localparam int STORE_DEPTH = NUM_PIPES * PIPE_DEPTH;

    localparam int PIPE_W  = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
    localparam int IDX_W   = $clog2(PIPE_DEPTH);
    localparam int CNT_W   = $clog2(PIPE_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STORE_DEPTH);

    localparam int KIND_W   = 3;
    localparam int HANDLE_W = 4;
    localparam int STATUS_W = 3;
    localparam int BYTE_W   = 8;

    localparam logic [HANDLE_W-1:0] FIRST_HANDLE = HANDLE_W'(3);

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE = 3'd0,
        KIND_WRITE  = 3'd1,
        KIND_READ   = 3'd2,
        KIND_CLOSE  = 3'd3,
        KIND_CLEAR  = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_BAD_HANDLE = 3'd1,
        STAT_EMPTY      = 3'd2,
        STAT_FULL       = 3'd3,
        STAT_NO_FREE    = 3'd4
    } status_t;

    // One entry of the pipe table.
    typedef struct packed {
        logic [IDX_W-1:0] rd_idx;
        logic [IDX_W-1:0] wr_idx;
        logic [CNT_W-1:0] count;
    } pipe_entry_t;

    localparam int ENTRY_W = $bits(pipe_entry_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESULT
    } state_t;

endpackage

// ===== hdl/mcbp_ram.sv =====
// ----------------------------------------------------------------------------
// mcbp_ram: simple dual-port synchronous RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module mcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next enabled read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/multi_channel_byte_pipe.sv =====
// ----------------------------------------------------------------------------
// multi_channel_byte_pipe: several byte FIFOs sharing one ring-buffer store
// Each item creates, writes, reads, closes or clears one pipe and yields
// exactly one result item carrying a status.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Ports                                        | Handshake
//  --------+-----------+----------------------------------------------+----------
//  s_      | in        | s_kind, s_handle, s_data_in, s_burst_last    | s_valid/s_ready
//  m_      | out       | m_status, m_handle_out, m_data_out,          | m_valid/m_ready
//          |           | m_burst_last_out                             |
//
// Every item passes in turn through accept and pipe table read, execute
// with table write-back and byte store access, then load of the output
// register. The pipe table and the byte store both have registered reads
// and are visited one after the other.
// Reset (aresetn low, synchronous) closes all pipes and empties the output
// register; the memories are not cleared, since a pipe entry is zeroed when
// the pipe is created and a byte is only read after it has been written.
// A stalled result stays in the output register; the block can take the next
// item meanwhile and only waits at the end of that item if the result is
// still not taken.
//
module multi_channel_byte_pipe
    import mcbp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KIND_W-1:0]   s_kind,
    input  logic [HANDLE_W-1:0] s_handle,
    input  logic [BYTE_W-1:0]   s_data_in,
    input  logic                s_burst_last,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [HANDLE_W-1:0] m_handle_out,
    output logic [BYTE_W-1:0]   m_data_out,
    output logic                m_burst_last_out
);

    // Controller state.
    state_t state_reg, state_next;

    // Open flags live in flip-flops so that reset closes every pipe at once.
    logic [NUM_PIPES-1:0] open_reg, open_next;

    // The accepted item and what the lookup stage found out about it.
    logic [KIND_W-1:0]   kind_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [BYTE_W-1:0]   din_reg;
    logic                last_reg;
    logic [PIPE_W-1:0]   pipe_reg;
    logic                hit_reg;    // handle names an open pipe
    logic                free_reg;   // a closed pipe was found for create

    // Outcome of the execute cycle.
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [HANDLE_W-1:0] hout_reg, hout_next;
    logic                rd_ok_reg, rd_ok_next;

    // Output register.
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [HANDLE_W-1:0] m_handle_reg;
    logic [BYTE_W-1:0]   m_data_reg;
    logic                m_last_reg;

    // Controller outputs.
    logic accept;
    logic exec_en;
    logic load_out;

    // Handle decoding and the free pipe search on the incoming item.
    logic [HANDLE_W-1:0] h_off;
    logic                h_in_range;
    logic [PIPE_W-1:0]   h_pipe;
    logic                h_hit;
    logic                free_found;
    logic [PIPE_W-1:0]   free_pipe;
    logic [PIPE_W-1:0]   look_pipe;

    // Memory ports.
    pipe_entry_t         entry_rd;
    pipe_entry_t         entry_wr;
    logic                tbl_we;
    logic [ENTRY_W-1:0]  tbl_rdata;
    logic                byte_we;
    logic                byte_re;
    logic [ADDR_W-1:0]   byte_addr;
    logic [BYTE_W-1:0]   byte_rdata;
    logic [IDX_W-1:0]    byte_idx;

    // ------------------------------------------------------------------
    // Lookup of the incoming item
    // ------------------------------------------------------------------
    assign h_off      = s_handle - FIRST_HANDLE;
    assign h_in_range = (s_handle >= FIRST_HANDLE) && (32'(h_off) < NUM_PIPES);
    assign h_pipe     = PIPE_W'(h_off);
    assign h_hit      = h_in_range && open_reg[h_pipe];

    // Lowest numbered closed pipe.
    always_comb begin
        free_found = 1'b0;
        free_pipe  = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--) begin
            if (!open_reg[i]) begin
                free_found = 1'b1;
                free_pipe  = PIPE_W'(i);
            end
        end
    end

    assign look_pipe = (s_kind == KIND_CREATE) ? free_pipe : h_pipe;

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg   <= s_kind;
            handle_reg <= s_handle;
            din_reg    <= s_data_in;
            last_reg   <= s_burst_last;
            pipe_reg   <= look_pipe;
            hit_reg    <= h_hit;
            free_reg   <= free_found;
        end
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        exec_en  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_EXEC: begin
                exec_en = 1'b1;
            end
            S_RESULT: begin
                load_out = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            open_reg  <= '0;
        end else begin
            state_reg <= state_next;
            open_reg  <= open_next;
        end
    end

    // ------------------------------------------------------------------
    // Execute: read-modify-write of the pipe table entry
    // ------------------------------------------------------------------
    assign entry_rd = pipe_entry_t'(tbl_rdata);

    always_comb begin
        open_next   = open_reg;
        status_next = status_reg;
        hout_next   = hout_reg;
        rd_ok_next  = rd_ok_reg;
        entry_wr    = '0;
        tbl_we      = 1'b0;
        byte_we     = 1'b0;
        byte_re     = 1'b0;
        byte_idx    = entry_rd.wr_idx;

        if (exec_en) begin
            status_next = STAT_BAD_HANDLE;
            hout_next   = handle_reg;
            rd_ok_next  = 1'b0;
            case (kind_reg)
                KIND_CREATE: begin
                    if (free_reg) begin
                        status_next         = STAT_OK;
                        hout_next           = HANDLE_W'(pipe_reg) + FIRST_HANDLE;
                        open_next[pipe_reg] = 1'b1;
                        tbl_we              = 1'b1;
                    end else begin
                        status_next = STAT_NO_FREE;
                    end
                end
                KIND_WRITE: begin
                    if (hit_reg) begin
                        if (entry_rd.count == CNT_W'(PIPE_DEPTH)) begin
                            status_next = STAT_FULL;
                        end else begin
                            status_next     = STAT_OK;
                            byte_we         = 1'b1;
                            byte_idx        = entry_rd.wr_idx;
                            entry_wr        = entry_rd;
                            entry_wr.wr_idx = (entry_rd.wr_idx == IDX_W'(PIPE_DEPTH - 1))
                                              ? '0 : entry_rd.wr_idx + 1'b1;
                            entry_wr.count  = entry_rd.count + 1'b1;
                            tbl_we          = 1'b1;
                        end
                    end
                end
                KIND_READ: begin
                    if (hit_reg) begin
                        if (entry_rd.count == '0) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            status_next     = STAT_OK;
                            rd_ok_next      = 1'b1;
                            byte_re         = 1'b1;
                            byte_idx        = entry_rd.rd_idx;
                            entry_wr        = entry_rd;
                            entry_wr.rd_idx = (entry_rd.rd_idx == IDX_W'(PIPE_DEPTH - 1))
                                              ? '0 : entry_rd.rd_idx + 1'b1;
                            entry_wr.count  = entry_rd.count - 1'b1;
                            tbl_we          = 1'b1;
                        end
                    end
                end
                KIND_CLOSE: begin
                    if (hit_reg) begin
                        status_next         = STAT_OK;
                        open_next[pipe_reg] = 1'b0;
                        tbl_we              = 1'b1;
                    end
                end
                KIND_CLEAR: begin
                    if (hit_reg) begin
                        status_next = STAT_OK;
                        tbl_we      = 1'b1;
                    end
                end
                default: begin
                    status_next = STAT_BAD_HANDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        hout_reg   <= hout_next;
        rd_ok_reg  <= rd_ok_next;
    end

    // Pipe p owns the PIPE_DEPTH bytes starting at p * PIPE_DEPTH.
    assign byte_addr = ADDR_W'(pipe_reg) * ADDR_W'(PIPE_DEPTH) + ADDR_W'(byte_idx);

    mcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_PIPES)
    ) u_pipe_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (pipe_reg),
        .wdata (ENTRY_W'(entry_wr)),
        .re    (accept),
        .raddr (look_pipe),
        .rdata (tbl_rdata)
    );

    mcbp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_byte_store (
        .aclk  (aclk),
        .we    (byte_we),
        .waddr (byte_addr),
        .wdata (din_reg),
        .re    (byte_re),
        .raddr (byte_addr),
        .rdata (byte_rdata)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // The byte store read data holds until the next read, so a stalled
    // result still picks up the right byte here.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_status_reg <= status_reg;
            m_handle_reg <= hout_reg;
            m_data_reg   <= rd_ok_reg ? byte_rdata : '0;
            m_last_reg   <= last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_handle_out     = m_handle_reg;
    assign m_data_out       = m_data_reg;
    assign m_burst_last_out = m_last_reg;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multi_channel_byte_pipe
// Drives create, write, read, close and clear items into the block,
// predicts each result from a behavioral copy of the pipe table, and
// checks every result item field by field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
    import mcbp_pkg::*;

    // One request on the input channel.
    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [BYTE_W-1:0]   data;
        logic                last;
    } pipe_req_t;

    // One predicted result item.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic [BYTE_W-1:0]   data;
        logic                last;
    } pipe_result_t;

    // Kinds above the last defined operation must be rejected as bad handles.
    localparam logic [KIND_W-1:0] KIND_UNDEF_LO = KIND_W'(5);
    localparam logic [KIND_W-1:0] KIND_UNDEF_HI = KIND_W'(7);
    localparam int LAST_HANDLE = NUM_PIPES + 2;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;

    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind       = '0;
    logic [HANDLE_W-1:0] s_handle     = '0;
    logic [BYTE_W-1:0]   s_data_in    = '0;
    logic                s_burst_last = 1'b0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [HANDLE_W-1:0] m_handle_out;
    logic [BYTE_W-1:0]   m_data_out;
    logic                m_burst_last_out;

    multi_channel_byte_pipe dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_handle         (s_handle),
        .s_data_in        (s_data_in),
        .s_burst_last     (s_burst_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_handle_out     (m_handle_out),
        .m_data_out       (m_data_out),
        .m_burst_last_out (m_burst_last_out)
    );

    // Period of 20: ten units high, ten units low.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Requests waiting to be driven, and results waiting to be seen.
    pipe_req_t    pending_requests[$];
    pipe_result_t expected_results[$];

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // Behavioral copy of the pipe table and the shared byte store.
    logic                pipe_open [NUM_PIPES];
    logic [IDX_W-1:0]    rd_ptr    [NUM_PIPES];
    logic [IDX_W-1:0]    wr_ptr    [NUM_PIPES];
    logic [CNT_W-1:0]    fill_cnt  [NUM_PIPES];
    logic [BYTE_W-1:0]   byte_mem  [STORE_DEPTH];

    // The stimulus generator keeps its own notion of which pipes are open so
    // that most items name a live pipe and get past the handle check.
    bit gen_open [NUM_PIPES];

    initial begin
        for (int i = 0; i < NUM_PIPES; i++) begin
            pipe_open[i] = 1'b0;
            rd_ptr[i]    = '0;
            wr_ptr[i]    = '0;
            fill_cnt[i]  = '0;
            gen_open[i]  = 1'b0;
        end
    end

    // Returns the pipe index a handle names, or -1 when it is out of range.
    function automatic int handle_slot(input logic [HANDLE_W-1:0] handle);
        int slot;
        slot = int'(handle) - int'(FIRST_HANDLE);
        if (slot < 0 || slot >= NUM_PIPES)
            return -1;
        return slot;
    endfunction

    // Applies one accepted item to the pipe table copy and queues the
    // result item that the block must return for it.
    task automatic apply_pipe_op(input logic [KIND_W-1:0] kind,
                                 input logic [HANDLE_W-1:0] handle,
                                 input logic [BYTE_W-1:0] data,
                                 input logic last);
        pipe_result_t res;
        int           slot;
        bit           found;
        int           base;
        res.status = STAT_BAD_HANDLE;
        res.handle = handle;
        res.data   = '0;
        res.last   = last;
        slot       = handle_slot(handle);
        if (kind == KIND_CREATE) begin
            // The lowest closed pipe is taken; the handle input plays no part.
            res.status = STAT_NO_FREE;
            found = 1'b0;
            for (int i = 0; i < NUM_PIPES; i++) begin
                if (!found && !pipe_open[i]) begin
                    found        = 1'b1;
                    pipe_open[i] = 1'b1;
                    rd_ptr[i]    = '0;
                    wr_ptr[i]    = '0;
                    fill_cnt[i]  = '0;
                    res.status   = STAT_OK;
                    res.handle   = HANDLE_W'(i + int'(FIRST_HANDLE));
                end
            end
        end else if (kind <= KIND_CLEAR && slot >= 0 && pipe_open[slot]) begin
            base = slot * PIPE_DEPTH;
            case (kind)
                KIND_WRITE: begin
                    if (int'(fill_cnt[slot]) >= PIPE_DEPTH) begin
                        res.status = STAT_FULL;
                    end else begin
                        byte_mem[base + int'(wr_ptr[slot])] = data;
                        wr_ptr[slot]   = IDX_W'((int'(wr_ptr[slot]) + 1) % PIPE_DEPTH);
                        fill_cnt[slot] = fill_cnt[slot] + 1'b1;
                        res.status     = STAT_OK;
                    end
                end
                KIND_READ: begin
                    if (fill_cnt[slot] == '0) begin
                        res.status = STAT_EMPTY;
                    end else begin
                        res.data       = byte_mem[base + int'(rd_ptr[slot])];
                        rd_ptr[slot]   = IDX_W'((int'(rd_ptr[slot]) + 1) % PIPE_DEPTH);
                        fill_cnt[slot] = fill_cnt[slot] - 1'b1;
                        res.status     = STAT_OK;
                    end
                end
                KIND_CLOSE: begin
                    // Bytes still held are simply dropped.
                    pipe_open[slot] = 1'b0;
                    rd_ptr[slot]    = '0;
                    wr_ptr[slot]    = '0;
                    fill_cnt[slot]  = '0;
                    res.status      = STAT_OK;
                end
                default: begin
                    rd_ptr[slot]   = '0;
                    wr_ptr[slot]   = '0;
                    fill_cnt[slot] = '0;
                    res.status     = STAT_OK;
                end
            endcase
        end
        expected_results.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s is %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Queues a request and tracks the open pipes the way the block will.
    task automatic queue_request(input logic [KIND_W-1:0] kind,
                                 input logic [HANDLE_W-1:0] handle,
                                 input logic [BYTE_W-1:0] data,
                                 input logic last);
        pipe_req_t req;
        int        slot;
        bit        found;
        req.kind   = kind;
        req.handle = handle;
        req.data   = data;
        req.last   = last;
        pending_requests.push_back(req);
        slot = handle_slot(handle);
        if (kind == KIND_CREATE) begin
            found = 1'b0;
            for (int i = 0; i < NUM_PIPES; i++) begin
                if (!found && !gen_open[i]) begin
                    found       = 1'b1;
                    gen_open[i] = 1'b1;
                end
            end
        end else if (kind == KIND_CLOSE && slot >= 0) begin
            gen_open[slot] = 1'b0;
        end
    endtask

    // Picks the handle of a random open pipe, or any in-range handle when
    // none is open.
    function automatic logic [HANDLE_W-1:0] pick_open_handle();
        int open_list[$];
        for (int i = 0; i < NUM_PIPES; i++)
            if (gen_open[i])
                open_list.push_back(i);
        if (open_list.size() == 0)
            return HANDLE_W'($urandom_range(LAST_HANDLE, int'(FIRST_HANDLE)));
        return HANDLE_W'(open_list[$urandom_range(open_list.size() - 1)]
                         + int'(FIRST_HANDLE));
    endfunction

    // Mostly well-formed traffic on live pipes, with some noise on random
    // handles and undefined kinds.
    task automatic queue_random_request();
        int                  pick;
        logic [BYTE_W-1:0]   data;
        logic                last;
        pick = $urandom_range(99);
        data = BYTE_W'($urandom);
        last = 1'($urandom);
        if (pick < 12)
            queue_request(KIND_CREATE, HANDLE_W'($urandom), data, last);
        else if (pick < 45)
            queue_request(KIND_WRITE, pick_open_handle(), data, last);
        else if (pick < 78)
            queue_request(KIND_READ, pick_open_handle(), data, last);
        else if (pick < 84)
            queue_request(KIND_CLOSE, pick_open_handle(), data, last);
        else if (pick < 88)
            queue_request(KIND_CLEAR, pick_open_handle(), data, last);
        else if (pick < 94)
            queue_request(KIND_W'($urandom_range(int'(KIND_CLEAR), int'(KIND_WRITE))),
                          HANDLE_W'($urandom), data, last);
        else
            queue_request(KIND_W'($urandom_range(int'(KIND_UNDEF_HI), int'(KIND_UNDEF_LO))),
                          HANDLE_W'($urandom), data, last);
    endtask

    // Fills one pipe past its depth, which walks the write index around the
    // ring and hits the full answer. The random traffic that follows reads back
    // only part of the stored bytes and checks them.
    task automatic queue_fill_burst();
        logic [HANDLE_W-1:0] handle;
        if (pick_open_handle() == '0 || !gen_open[handle_slot(pick_open_handle())])
            queue_request(KIND_CREATE, '0, '0, 1'b0);
        handle = pick_open_handle();
        queue_request(KIND_CLEAR, handle, '0, 1'b0);
        for (int i = 0; i <= PIPE_DEPTH; i++)
            queue_request(KIND_WRITE, handle, BYTE_W'($urandom), 1'(i == PIPE_DEPTH));
    endtask

    // Driver: presents the next pending request and predicts each one that
    // the block accepts. Valid is only dropped when the slot is free and the
    // sender idles or has nothing left to send, so an item is never withdrawn.
    always @(posedge aclk) begin : drive_requests
        pipe_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                apply_pipe_op(s_kind, s_handle, s_data_in, s_burst_last);
            if (!s_valid || s_ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    s_valid      <= 1'b1;
                    s_kind       <= req.kind;
                    s_handle     <= req.handle;
                    s_data_in    <= req.data;
                    s_burst_last <= req.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes each result item that the block hands over and
    // compares it with the oldest prediction.
    always @(posedge aclk) begin : check_results
        pipe_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result item with none pending, status",
                                    int'(m_status), -1);
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", int'(m_status), int'(want.status));
                    if (m_handle_out !== want.handle)
                        report_mismatch("handle_out", int'(m_handle_out), int'(want.handle));
                    if (m_data_out !== want.data)
                        report_mismatch("data_out", int'(m_data_out), int'(want.data));
                    if (m_burst_last_out !== want.last)
                        report_mismatch("burst_last_out", int'(m_burst_last_out),
                                        int'(want.last));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Main sequence: reset, a directed opening, then four random phases
    // that differ in how often each side idles; the first also fills a pipe.
    initial begin : run_sequence
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 71, 0, 8};
        recv_pct = '{0, 0, 71, 8};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening. A read on a pipe that was never created is
        // rejected before anything else has happened.
        queue_request(KIND_READ,   4'd3,  8'h00, 1'b0);
        queue_request(KIND_CREATE, 4'd15, 8'h00, 1'b1);
        queue_request(KIND_WRITE,  4'd3,  8'h00, 1'b0);
        queue_request(KIND_WRITE,  4'd3,  8'hFF, 1'b1);
        queue_request(KIND_READ,   4'd3,  8'h00, 1'b0);
        queue_request(KIND_READ,   4'd3,  8'h00, 1'b1);
        // The pipe is now empty, so this read reports empty.
        queue_request(KIND_READ,   4'd3,  8'h00, 1'b0);
        // Handles below the first one and above the last one.
        queue_request(KIND_WRITE,  4'd0,  8'h11, 1'b0);
        queue_request(KIND_WRITE,  4'd2,  8'h22, 1'b1);
        queue_request(KIND_WRITE,  HANDLE_W'(LAST_HANDLE + 1), 8'h33, 1'b0);
        queue_request(KIND_WRITE,  4'd15, 8'h44, 1'b1);
        // Undefined kinds on a live handle.
        queue_request(KIND_UNDEF_LO, 4'd3, 8'h55, 1'b0);
        queue_request(KIND_UNDEF_HI, 4'd3, 8'h66, 1'b1);
        // Open every remaining pipe, then one create too many.
        for (int i = 1; i < NUM_PIPES; i++)
            queue_request(KIND_CREATE, 4'd0, 8'h00, 1'b0);
        queue_request(KIND_CREATE, 4'd9, 8'h00, 1'b1);
        // Clear keeps the pipe open but drops its bytes.
        queue_request(KIND_WRITE,  HANDLE_W'(LAST_HANDLE), 8'hA5, 1'b0);
        queue_request(KIND_CLEAR,  HANDLE_W'(LAST_HANDLE), 8'h00, 1'b0);
        queue_request(KIND_READ,   HANDLE_W'(LAST_HANDLE), 8'h00, 1'b1);
        // Close with a byte still held; the closed handle is then rejected,
        // and the next create reuses the pipe and finds it empty.
        queue_request(KIND_WRITE,  4'd4,  8'h5A, 1'b0);
        queue_request(KIND_CLOSE,  4'd4,  8'h00, 1'b1);
        queue_request(KIND_WRITE,  4'd4,  8'h77, 1'b0);
        queue_request(KIND_CREATE, 4'd0,  8'h00, 1'b0);
        queue_request(KIND_READ,   4'd4,  8'h00, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            if (phase == 0)
                queue_fill_burst();
            for (int n = 0; n < 35; n++)
                queue_random_request();
            while (pending_requests.size() != 0)
                @(posedge aclk);
        end

        // Let the last item be taken, then every result come out, then let the
        // clock run on in case the block produces anything spurious.
        while (s_valid || pending_requests.size() != 0)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
